FILE: design/lsbe_pkg.sv
// shared types, constants and helpers of the led strip bit encoder
package lsbe_pkg;

  localparam int CHAN_W     = 8;
  localparam int TICK_W     = 8;
  localparam int SEL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int WORD_W     = 32;
  localparam int BITS_RGB   = 24;
  localparam int BITS_RGBW  = 32;
  localparam int BIT_CNT_W  = 5;

  // channel selector codes
  localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
  localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;
  localparam logic [SEL_W-1:0] SEL_NONE  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_SEL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_MODE = 3'd7;

  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
    logic [SEL_W-1:0]  first_sel;
    logic [SEL_W-1:0]  second_sel;
    logic [SEL_W-1:0]  third_sel;
    logic              white_mode;
  } lsbe_cfg_t;

  // queued pixel: word left aligned, msb goes out first
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is32;
    logic              last;
  } lsbe_entry_t;

  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              bit_value;
    logic              is_terminator;
    logic              last_symbol;
  } lsbe_sym_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BITS,
    BK_TERM
  } bk_state_t;

  function automatic logic [CHAN_W-1:0] pick_chan(
    input logic [SEL_W-1:0]  sel,
    input logic [CHAN_W-1:0] r,
    input logic [CHAN_W-1:0] g,
    input logic [CHAN_W-1:0] b
  );
    logic [CHAN_W-1:0] res;
    unique case (sel)
      SEL_RED:   res = r;
      SEL_GREEN: res = g;
      SEL_BLUE:  res = b;
      SEL_NONE:  res = '0;
      default:   res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/lsbe_ifs.sv
// pixel and symbol channel interfaces

interface lsbe_pix_if import lsbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] white;
  logic              last_pixel;

  modport source (output valid, red, green, blue, white, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, white, last_pixel, output ready);
endinterface

interface lsbe_sym_if import lsbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] high_ticks;
  logic [TICK_W-1:0] low_ticks;
  logic              bit_value;
  logic              is_terminator;
  logic              last_symbol;

  modport source (output valid, high_ticks, low_ticks, bit_value, is_terminator,
                  last_symbol, input ready);
  modport sink   (input valid, high_ticks, low_ticks, bit_value, is_terminator,
                  last_symbol, output ready);
endinterface

FILE: design/lsbe_cfg_regs.sv
// configuration register file
module lsbe_cfg_regs import lsbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output lsbe_cfg_t             cfg
);

  lsbe_cfg_t cfg_r;
  lsbe_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_HIGH:  cfg_nxt.zero_high  = cfg_data[TICK_W-1:0];
        REG_ZERO_LOW:   cfg_nxt.zero_low   = cfg_data[TICK_W-1:0];
        REG_ONE_HIGH:   cfg_nxt.one_high   = cfg_data[TICK_W-1:0];
        REG_ONE_LOW:    cfg_nxt.one_low    = cfg_data[TICK_W-1:0];
        REG_FIRST_SEL:  cfg_nxt.first_sel  = cfg_data[SEL_W-1:0];
        REG_SECOND_SEL: cfg_nxt.second_sel = cfg_data[SEL_W-1:0];
        REG_THIRD_SEL:  cfg_nxt.third_sel  = cfg_data[SEL_W-1:0];
        REG_WHITE_MODE: cfg_nxt.white_mode = cfg_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_high  <= '0;
      cfg_r.zero_low   <= '0;
      cfg_r.one_high   <= '0;
      cfg_r.one_low    <= '0;
      cfg_r.first_sel  <= SEL_GREEN;
      cfg_r.second_sel <= SEL_RED;
      cfg_r.third_sel  <= SEL_BLUE;
      cfg_r.white_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/lsbe_front.sv
// front end: takes pixels, orders channels and builds the queued word
module lsbe_front import lsbe_pkg::*; (
  lsbe_pix_if.sink    pix,
  input  lsbe_cfg_t   cfg,
  input  logic        q_full,
  output logic        push,
  output lsbe_entry_t entry
);

  logic [CHAN_W-1:0] byte_hi;
  logic [CHAN_W-1:0] byte_mid;
  logic [CHAN_W-1:0] byte_lo;

  assign byte_hi  = pick_chan(cfg.first_sel,  pix.red, pix.green, pix.blue);
  assign byte_mid = pick_chan(cfg.second_sel, pix.red, pix.green, pix.blue);
  assign byte_lo  = pick_chan(cfg.third_sel,  pix.red, pix.green, pix.blue);

  // rgb word sits in the top 24 bits; white fills the low byte in white mode
  always_comb begin
    entry.word = {byte_hi, byte_mid, byte_lo, CHAN_W'(0)};
    if (cfg.white_mode) begin
      entry.word[CHAN_W-1:0] = pix.white;
    end
    entry.is32 = cfg.white_mode;
    entry.last = pix.last_pixel;
  end

  assign pix.ready = !q_full;
  assign push      = pix.valid && !q_full;

endmodule

FILE: design/lsbe_fifo.sv
// small register queue between front and back
module lsbe_fifo import lsbe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lsbe_entry_t din,
  input  logic        pop,
  output logic        q_valid,
  output logic        q_full,
  output lsbe_entry_t dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lsbe_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign dout    = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(DEPTH) || pop))
    else $error("queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

FILE: design/lsbe_back.sv
// back end: serializes queued words into timed symbols
module lsbe_back import lsbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lsbe_cfg_t   cfg,
  input  logic        q_valid,
  input  lsbe_entry_t q_data,
  output logic        pop,
  lsbe_sym_if.source  sym
);

  bk_state_t            state_r, state_nxt;
  logic [WORD_W-1:0]    word_r;
  logic [BIT_CNT_W-1:0] cnt_r;
  logic                 last_r;
  logic                 out_valid_r;
  lsbe_sym_t            sym_r, sym_nxt;
  logic                 adv;
  logic                 emit;
  logic                 cur_bit;
  logic                 final_bit;

  assign adv       = !out_valid_r || sym.ready;
  assign cur_bit   = word_r[WORD_W-1];
  assign final_bit = (cnt_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) state_nxt = BK_BITS;
      end
      BK_BITS: begin
        if (adv && final_bit) begin
          if (last_r)       state_nxt = BK_TERM;
          else if (q_valid) state_nxt = BK_BITS;
          else              state_nxt = BK_IDLE;
        end
      end
      BK_TERM: begin
        if (adv) state_nxt = q_valid ? BK_BITS : BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop     = 1'b0;
    emit    = 1'b0;
    sym_nxt = '0;
    unique case (state_r)
      BK_IDLE: begin
        pop = q_valid;
      end
      BK_BITS: begin
        if (adv) begin
          emit                = 1'b1;
          sym_nxt.high_ticks  = cur_bit ? cfg.one_high : cfg.zero_high;
          sym_nxt.low_ticks   = cur_bit ? cfg.one_low : cfg.zero_low;
          sym_nxt.bit_value   = cur_bit;
          sym_nxt.last_symbol = final_bit && !last_r;
          pop                 = final_bit && !last_r && q_valid;
        end
      end
      BK_TERM: begin
        if (adv) begin
          emit                  = 1'b1;
          sym_nxt.is_terminator = 1'b1;
          sym_nxt.last_symbol   = 1'b1;
          pop                   = q_valid;
        end
      end
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r <= q_data.word;
      cnt_r  <= q_data.is32 ? BIT_CNT_W'(BITS_RGBW - 1) : BIT_CNT_W'(BITS_RGB - 1);
      last_r <= q_data.last;
    end else if (emit && state_r == BK_BITS) begin
      word_r <= {word_r[WORD_W-2:0], 1'b0};
      cnt_r  <= cnt_r - BIT_CNT_W'(1);
    end
    if (emit) sym_r <= sym_nxt;
  end

  assign sym.valid         = out_valid_r;
  assign sym.high_ticks    = sym_r.high_ticks;
  assign sym.low_ticks     = sym_r.low_ticks;
  assign sym.bit_value     = sym_r.bit_value;
  assign sym.is_terminator = sym_r.is_terminator;
  assign sym.last_symbol   = sym_r.last_symbol;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_term_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_TERM) |-> last_r)
    else $error("terminator for a pixel not marked last");

endmodule

FILE: design/led_strip_bit_encoder.sv
// top level of the led strip bit encoder
//
// in_pix carries one pixel per word (red, green, blue, white, last_pixel);
// out_sym carries one symbol per word: high/low durations in ticks, the data
// bit, a terminator flag and a flag on the final symbol of the pixel.
// cfg_we/cfg_index/cfg_data write the timing, channel order and white mode
// registers; write them only while no pixel is in flight.
// a pixel gives 24 symbols, or 32 in white mode, msb of the ordered word
// first; a pixel flagged last_pixel adds one terminator with zero durations.
// when the back end is idle, a taken pixel goes through the queue, the idle
// and bits states and the symbol output register before its first symbol
// shows on out_sym. throughput: one symbol per cycle while out_sym is ready
// and a pixel is queued, set by the single serializer in the back end.
// the front end converts a pixel in the cycle it is taken and parks it in a
// small queue, so the next pixels are taken while the current one is still
// going out; in_pix.ready drops only once the queue is full.
// when out_sym is stalled the symbol holds in its output register and the
// serializer waits; nothing is lost.
// reset (rst_n low, synchronous) empties the queue, drops out_sym.valid and
// restores the register defaults: zero timings, green-red-blue order, rgb mode.
module led_strip_bit_encoder import lsbe_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lsbe_pix_if.sink              in_pix,
  lsbe_sym_if.source            out_sym
);

  // register file, shared by both halves
  lsbe_cfg_t   cfg;

  // front-to-queue and queue-to-back signals
  logic        push;
  lsbe_entry_t entry;
  logic        q_full;
  logic        q_valid;
  lsbe_entry_t q_data;
  logic        pop;

  lsbe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // channel ordering and word build
  lsbe_front u_front (
    .pix    (in_pix),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .entry  (entry)
  );

  // decouples pixel intake from symbol output
  lsbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .din     (entry),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .dout    (q_data)
  );

  // bit serializer with registered output
  lsbe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .sym     (out_sym)
  );

endmodule

FILE: tb/led_strip_bit_encoder_test.sv
// self-checking testbench of the led strip bit encoder: pixels in, timed symbols out
module led_strip_bit_encoder_test import lsbe_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int RANDOM_SETUPS = 8;
  localparam int PIXELS_PER_SETUP = 60;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] white;
    logic              last_pixel;
  } pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsbe_pix_if pix_ch ();
  lsbe_sym_if sym_ch ();

  led_strip_bit_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (pix_ch.sink),
    .out_sym   (sym_ch.source)
  );

  // shadow of the block's registers, kept in step with every write
  lsbe_cfg_t  regs;

  // pixels waiting for the driver, and symbols the block still owes us
  pixel_t     pixels_to_send[$];
  lsbe_sym_t  symbols_due[$];

  pixel_t     on_bus;
  lsbe_sym_t  due_sym;
  int         pixels_issued;
  int         pixels_taken;
  int         symbols_checked;
  int         terminators_seen;
  int         setups;
  int         errors;
  int         cycles;

  // sender pacing
  int         burst_left;
  int         gap_left;

  // receiver pacing
  logic [31:0] rx_cycle;
  int          rx_taken;
  int          hold_left;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor: one pixel becomes 24 or 32 bit symbols plus an optional
  // terminator, using the shadow registers as they stand when it is taken
  // ---------------------------------------------------------------------
  function automatic logic [CHAN_W-1:0] color_for(logic [SEL_W-1:0] sel, pixel_t p);
    case (sel)
      SEL_RED:   return p.red;
      SEL_GREEN: return p.green;
      SEL_BLUE:  return p.blue;
      default:   return '0;   // selector none sends a zero byte
    endcase
  endfunction

  function automatic void encode_pixel(pixel_t p);
    logic [WORD_W-1:0] word;
    int                nbits;
    lsbe_sym_t         s;
    word  = {8'h00, color_for(regs.first_sel, p), color_for(regs.second_sel, p),
             color_for(regs.third_sel, p)};
    nbits = BITS_RGB;
    // white mode: white byte goes below the three colors
    if (regs.white_mode) begin
      word  = {word[23:0], p.white};
      nbits = BITS_RGBW;
    end
    for (int k = nbits - 1; k >= 0; k--) begin
      s.bit_value     = word[k];
      s.high_ticks    = word[k] ? regs.one_high : regs.zero_high;
      s.low_ticks     = word[k] ? regs.one_low  : regs.zero_low;
      s.is_terminator = 1'b0;
      // final data bit closes the pixel unless a terminator follows
      s.last_symbol   = !p.last_pixel && (k == 0);
      symbols_due.push_back(s);
    end
    if (p.last_pixel) begin
      s = '0;
      s.is_terminator = 1'b1;
      s.last_symbol   = 1'b1;
      symbols_due.push_back(s);
    end
  endfunction

  // ---------------------------------------------------------------------
  // driver: bursts of random length with random gaps, never drops valid
  // while a word is waiting for ready
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        encode_pixel(on_bus);
        pixels_taken++;
      end
      // only touch the bus when no word is stuck on it
      if (!(pix_ch.valid && !pix_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_ch.valid <= 1'b0;
        end else if (pixels_to_send.size() != 0) begin
          on_bus = pixels_to_send.pop_front();
          pix_ch.valid      <= 1'b1;
          pix_ch.red        <= on_bus.red;
          pix_ch.green      <= on_bus.green;
          pix_ch.blue       <= on_bus.blue;
          pix_ch.white      <= on_bus.white;
          pix_ch.last_pixel <= on_bus.last_pixel;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          // a third of the bursts run straight into the next one
          if (burst_left == 0) begin
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: ready pattern follows bits 9:8 of its cycle count, plus two long
  // hold-offs so the pixel queue fills and in_pix.ready drops
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      sym_ch.ready <= 1'b0;
      rx_cycle  = '0;
      rx_taken  = 0;
      hold_left = 0;
    end else begin
      if (sym_ch.valid && sym_ch.ready) begin
        rx_taken++;
        if (rx_taken == 1500 || rx_taken == 8000) begin
          hold_left = HOLD_CYCLES;
        end
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        sym_ch.ready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: sym_ch.ready <= 1'b1;                          // no stalls
          2'd1: sym_ch.ready <= ($urandom_range(9) < 7);       // light stalls
          2'd2: sym_ch.ready <= (rx_cycle[1:0] != 2'b11);      // low when rx_cycle[1:0] is 3
          default: sym_ch.ready <= ($urandom_range(3) == 0);   // heavy stalls
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: every symbol taken is checked against the oldest one due
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [TICK_W-1:0] want,
                                      logic [TICK_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && sym_ch.valid && sym_ch.ready) begin
      if (symbols_due.size() == 0) begin
        $error("symbol with nothing due: high %0h low %0h bit %0b term %0b last %0b",
               sym_ch.high_ticks, sym_ch.low_ticks, sym_ch.bit_value,
               sym_ch.is_terminator, sym_ch.last_symbol);
        errors++;
      end else begin
        due_sym = symbols_due.pop_front();
        check_field("high_ticks", due_sym.high_ticks, sym_ch.high_ticks);
        check_field("low_ticks", due_sym.low_ticks, sym_ch.low_ticks);
        check_field("bit_value", TICK_W'(due_sym.bit_value), TICK_W'(sym_ch.bit_value));
        check_field("is_terminator", TICK_W'(due_sym.is_terminator),
                    TICK_W'(sym_ch.is_terminator));
        check_field("last_symbol", TICK_W'(due_sym.last_symbol),
                    TICK_W'(sym_ch.last_symbol));
        symbols_checked++;
        if (due_sym.is_terminator) begin
          terminators_seen++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d symbols still due", cycles,
               symbols_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // register writes: one per cycle, we lowered after the last one
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    // narrow registers keep only their low bits
    case (idx)
      REG_ZERO_HIGH:  regs.zero_high  = data;
      REG_ZERO_LOW:   regs.zero_low   = data;
      REG_ONE_HIGH:   regs.one_high   = data;
      REG_ONE_LOW:    regs.one_low    = data;
      REG_FIRST_SEL:  regs.first_sel  = data[SEL_W-1:0];
      REG_SECOND_SEL: regs.second_sel = data[SEL_W-1:0];
      REG_THIRD_SEL:  regs.third_sel  = data[SEL_W-1:0];
      REG_WHITE_MODE: regs.white_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic program_setup(logic [7:0] zh, logic [7:0] zl, logic [7:0] oh,
                               logic [7:0] ol, logic [7:0] s1, logic [7:0] s2,
                               logic [7:0] s3, logic [7:0] wm);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_FIRST_SEL, s1);
    write_reg(REG_SECOND_SEL, s2);
    write_reg(REG_THIRD_SEL, s3);
    write_reg(REG_WHITE_MODE, wm);
    @(posedge clk);
    cfg_we <= 1'b0;
    setups++;
  endtask

  // timing value biased toward the extremes
  function automatic logic [7:0] pick_ticks(int flavor);
    if (flavor == 0) return 8'h00;
    if (flavor == 1) return 8'hFF;
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] w, logic last);
    pixels_to_send.push_back({r, g, b, w, last});
    pixels_issued++;
  endtask

  // wait until every pixel is taken and every symbol has come back
  task automatic drain();
    while (pixels_taken != pixels_issued || symbols_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_ZERO_HIGH;
    cfg_data  = '0;
    pix_ch.valid      = 1'b0;
    pix_ch.red        = '0;
    pix_ch.green      = '0;
    pix_ch.blue       = '0;
    pix_ch.white      = '0;
    pix_ch.last_pixel = 1'b0;
    sym_ch.ready      = 1'b0;
    pixels_issued    = 0;
    pixels_taken     = 0;
    symbols_checked  = 0;
    terminators_seen = 0;
    setups = 0;
    errors = 0;
    cycles = 0;

    // reset defaults: zero timings, green-red-blue, rgb
    regs = '0;
    regs.first_sel  = SEL_GREEN;
    regs.second_sel = SEL_RED;
    regs.third_sel  = SEL_BLUE;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // defaults straight out of reset
    queue_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
    queue_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);
    drain();

    // red-green-blue with white appended, all-zero and all-one pixels
    program_setup(8'h01, 8'hFE, 8'h80, 8'h7F, 8'(SEL_RED), 8'(SEL_GREEN),
                  8'(SEL_BLUE), 8'h01);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_pixel(8'h80, 8'h01, 8'hAA, 8'h55, 1'b0);
    queue_pixel(8'h01, 8'h80, 8'h55, 8'hAA, 1'b1);
    queue_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
    drain();

    // wide data: none, blue, none and rgb mode; white must be ignored
    program_setup(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFE, 8'h07, 8'hFE);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
    drain();

    // blue, none, green with white mode set through a wide value
    program_setup(8'h55, 8'hAA, 8'hAA, 8'h55, {6'h3F, SEL_BLUE}, 8'(SEL_NONE),
                  8'(SEL_GREEN), 8'h81);
    queue_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
    queue_pixel(8'h12, 8'hFF, 8'hEE, 8'h01, 1'b1);
    drain();

    // random setups, the first two with all-zero and all-one timings
    for (int ph = 0; ph < RANDOM_SETUPS; ph++) begin
      program_setup(pick_ticks(ph), pick_ticks(ph), pick_ticks(ph), pick_ticks(ph),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
      for (int n = 0; n < PIXELS_PER_SETUP; n++) begin
        queue_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                    $urandom_range(3) == 0);
      end
      drain();
    end

    // let any stray symbol show up before calling it
    repeat (20) @(posedge clk);

    $display("covered %0d pixels in %0d register setups: %0d symbols checked,",
             pixels_taken, setups, symbols_checked);
    $display("including %0d frame terminators, in %0d cycles", terminators_seen, cycles);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lsbe_pkg.sv
design/lsbe_ifs.sv
design/lsbe_cfg_regs.sv
design/lsbe_front.sv
design/lsbe_fifo.sv
design/lsbe_back.sv
design/led_strip_bit_encoder.sv
tb/led_strip_bit_encoder_test.sv
